FILE: hw/rtl/gcg_pkg.sv
// Shared types and constants for the glycan child generator.
package gcg_pkg;

  localparam int BRANCHES         = 4;
  localparam int BRANCH_COUNT_MAX = 15;
  localparam int MAX_RESULTS      = 4;
  // Branches that have a nibble in the packed 16-bit fields.
  localparam int FIELD_BRANCHES   = 4;
  localparam int FLD_LANES        = (BRANCHES < FIELD_BRANCHES) ? BRANCHES : FIELD_BRANCHES;
  // Candidate 0 is the core change; candidates 1..BRANCHES are the branch lanes.
  localparam int NCAND            = BRANCHES + 1;
  localparam int CNT_LIM          = (BRANCH_COUNT_MAX < 15) ? BRANCH_COUNT_MAX : 15;
  localparam int CNT_W            = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam logic [1:0] CORE_GLCNAC_FULL = 2'd2;
  localparam logic [1:0] CORE_MAN_FULL    = 2'd3;

  typedef enum logic [2:0] {
    OP_GLCNAC = 3'd0,
    OP_MAN    = 3'd1,
    OP_GAL    = 3'd2,
    OP_FUC    = 3'd3,
    OP_NEUAC  = 3'd4,
    OP_NEUGC  = 3'd5
  } op_t;

  typedef struct packed {
    logic [1:0]  cg;
    logic [1:0]  cm;
    logic        cf;
    logic        bs;
    logic [15:0] gn;
    logic [15:0] ga;
    logic [3:0]  fu;
    logic [3:0]  na;
    logic [3:0]  ng;
  } tab_t;

  typedef struct packed {
    logic [3:0] gn;
    logic [3:0] ga;
    logic       fu;
    logic       na;
    logic       ng;
  } lane_t;

endpackage

FILE: hw/rtl/gcg_in_if.sv
// Input channel: one structure table plus the sugar to add.
interface gcg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  core_glcnac;
  logic [1:0]  core_man;
  logic        core_fuc;
  logic        bisect;
  logic [15:0] branch_glcnac;
  logic [15:0] branch_gal;
  logic [3:0]  branch_fuc;
  logic [3:0]  branch_neuac;
  logic [3:0]  branch_neugc;

  modport source (output valid, op, core_glcnac, core_man, core_fuc, bisect, branch_glcnac,
                  branch_gal, branch_fuc, branch_neuac, branch_neugc, input ready);
  modport sink (input valid, op, core_glcnac, core_man, core_fuc, bisect, branch_glcnac,
                branch_gal, branch_fuc, branch_neuac, branch_neugc, output ready);
endinterface

FILE: hw/rtl/gcg_out_if.sv
// Result channel: one child table per beat.
interface gcg_out_if;
  logic        valid;
  logic        ready;
  logic        has_child;
  logic        last;
  logic [1:0]  child_core_glcnac;
  logic [1:0]  child_core_man;
  logic        child_core_fuc;
  logic        child_bisect;
  logic [15:0] child_branch_glcnac;
  logic [15:0] child_branch_gal;
  logic [3:0]  child_branch_fuc;
  logic [3:0]  child_branch_neuac;
  logic [3:0]  child_branch_neugc;

  modport source (output valid, has_child, last, child_core_glcnac, child_core_man,
                  child_core_fuc, child_bisect, child_branch_glcnac, child_branch_gal,
                  child_branch_fuc, child_branch_neuac, child_branch_neugc, input ready);
  modport sink (input valid, has_child, last, child_core_glcnac, child_core_man,
                child_core_fuc, child_bisect, child_branch_glcnac, child_branch_gal,
                child_branch_fuc, child_branch_neuac, child_branch_neugc, output ready);
endinterface

FILE: hw/rtl/glycan_child_generator.sv
// Glycan child generator top level: input register, branch lanes and merge stage.
// Each input beat is registered, its core rule and every branch lane are checked
// in parallel, and the merge stage then sends the children out in order, one per
// cycle unless the output stalls, through a single output register, flagging the
// final one with last. An item gives at most four children, a cap set by the
// MAX_RESULTS count; a structure with no child gives one beat with has_child low.
// A new item is taken while the previous one is still being emitted.
module glycan_child_generator (
  input  logic      clk,
  input  logic      rst_n,
  gcg_in_if.sink    in_ch,
  gcg_out_if.source out_ch
);

  logic                         a_v_r, a_v_nxt;
  gcg_pkg::op_t                 a_op_r;
  gcg_pkg::tab_t                a_tab_r;
  logic                         a_take;
  logic                         in_take;

  gcg_pkg::lane_t               lanes [gcg_pkg::BRANCHES];
  logic [gcg_pkg::BRANCHES-1:0] lane_cand;
  logic                         full_core;
  logic                         core_fuc_case;
  logic                         core_cand;
  logic                         branch_gate;
  logic [gcg_pkg::NCAND-1:0]    mask;

  assign in_ch.ready = !a_v_r || a_take;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign a_v_nxt     = in_take ? 1'b1 : (a_take ? 1'b0 : a_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op_r     <= gcg_pkg::op_t'(in_ch.op);
      a_tab_r.cg <= in_ch.core_glcnac;
      a_tab_r.cm <= in_ch.core_man;
      a_tab_r.cf <= in_ch.core_fuc;
      a_tab_r.bs <= in_ch.bisect;
      a_tab_r.gn <= in_ch.branch_glcnac;
      a_tab_r.ga <= in_ch.branch_gal;
      a_tab_r.fu <= in_ch.branch_fuc;
      a_tab_r.na <= in_ch.branch_neuac;
      a_tab_r.ng <= in_ch.branch_neugc;
    end
  end

  for (genvar i = 0; i < gcg_pkg::BRANCHES; i++) begin : g_lane
    if (i < gcg_pkg::FIELD_BRANCHES) begin : g_fld
      assign lanes[i].gn = a_tab_r.gn[i*4 +: 4];
      assign lanes[i].ga = a_tab_r.ga[i*4 +: 4];
      assign lanes[i].fu = a_tab_r.fu[i];
      assign lanes[i].na = a_tab_r.na[i];
      assign lanes[i].ng = a_tab_r.ng[i];
    end else begin : g_zero
      assign lanes[i] = '0;
    end

    gcg_lane u_lane (
      .op       (a_op_r),
      .has_prev ((i != 0) ? 1'b1 : 1'b0),
      .cur      (lanes[i]),
      .prv      (lanes[(i != 0) ? i - 1 : 0]),
      .cand     (lane_cand[i])
    );
  end

  assign full_core     = (a_tab_r.cg == gcg_pkg::CORE_GLCNAC_FULL) &&
                         (a_tab_r.cm == gcg_pkg::CORE_MAN_FULL);
  assign core_fuc_case = (a_tab_r.cg == 2'd1) && (a_tab_r.cm == 2'd0) && !a_tab_r.cf;

  always_comb begin
    case (a_op_r)
      gcg_pkg::OP_GLCNAC: begin
        core_cand   = (a_tab_r.cg < gcg_pkg::CORE_GLCNAC_FULL) ||
                      (full_core && !a_tab_r.bs && (lanes[0].gn == 4'd0));
        branch_gate = full_core;
      end
      gcg_pkg::OP_MAN: begin
        core_cand   = (a_tab_r.cg == gcg_pkg::CORE_GLCNAC_FULL) &&
                      (a_tab_r.cm < gcg_pkg::CORE_MAN_FULL);
        branch_gate = 1'b0;
      end
      gcg_pkg::OP_FUC: begin
        core_cand   = core_fuc_case;
        branch_gate = !core_fuc_case;
      end
      gcg_pkg::OP_GAL, gcg_pkg::OP_NEUAC, gcg_pkg::OP_NEUGC: begin
        core_cand   = 1'b0;
        branch_gate = 1'b1;
      end
      default: begin
        core_cand   = 1'b0;
        branch_gate = 1'b0;
      end
    endcase
  end

  assign mask = {lane_cand & {gcg_pkg::BRANCHES{branch_gate}}, core_cand};

  gcg_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_valid (a_v_r),
    .a_op    (a_op_r),
    .a_tab   (a_tab_r),
    .a_mask  (mask),
    .a_take  (a_take),
    .out_ch  (out_ch)
  );

endmodule

FILE: hw/rtl/gcg_lane.sv
// One branch lane: decides whether this branch can take the sugar.
module gcg_lane (
  input  gcg_pkg::op_t  op,
  input  logic          has_prev,
  input  gcg_pkg::lane_t cur,
  input  gcg_pkg::lane_t prv,
  output logic          cand
);

  logic [4:0] ga_inc;
  logic       below_lim_gn;
  logic       below_lim_ga;

  assign ga_inc       = {1'b0, cur.ga} + 5'd1;
  assign below_lim_gn = cur.gn < 4'(gcg_pkg::CNT_LIM);
  assign below_lim_ga = cur.ga < 4'(gcg_pkg::CNT_LIM);

  // Branch order: a branch may only grow while it is below its left neighbor.
  always_comb begin
    case (op)
      gcg_pkg::OP_GLCNAC: begin
        cand = (!has_prev || (cur.gn < prv.gn)) && (cur.gn == cur.ga) &&
               !cur.fu && !cur.na && !cur.ng && below_lim_gn;
      end
      gcg_pkg::OP_GAL: begin
        cand = (!has_prev || (cur.ga < prv.ga)) && ({1'b0, cur.gn} == ga_inc) && below_lim_ga;
      end
      gcg_pkg::OP_FUC: begin
        cand = (!has_prev || (!cur.fu && prv.fu)) && !cur.fu && (cur.gn != 4'd0);
      end
      gcg_pkg::OP_NEUAC: begin
        cand = (!has_prev || (!cur.na && prv.na)) && (cur.gn != 4'd0) &&
               (cur.gn == cur.ga) && !cur.na && !cur.ng;
      end
      gcg_pkg::OP_NEUGC: begin
        cand = (!has_prev || (!cur.ng && prv.ng)) && (cur.gn != 4'd0) &&
               (cur.gn == cur.ga) && !cur.na && !cur.ng;
      end
      default: begin
        cand = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/gcg_emit.sv
// Merge stage: holds one item's candidate mask and emits one child per beat.
module gcg_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       a_valid,
  input  gcg_pkg::op_t               a_op,
  input  gcg_pkg::tab_t              a_tab,
  input  logic [gcg_pkg::NCAND-1:0]  a_mask,
  output logic                       a_take,
  gcg_out_if.source                  out_ch
);

  logic                      b_v_r, b_v_nxt;
  gcg_pkg::op_t              b_op_r;
  gcg_pkg::tab_t             b_tab_r;
  logic [gcg_pkg::NCAND-1:0] b_mask_r, b_mask_nxt;
  logic [gcg_pkg::CNT_W-1:0] b_cnt_r, b_cnt_nxt;

  logic                      o_v_r, o_v_nxt;
  logic                      o_has_r;
  logic                      o_last_r;
  gcg_pkg::tab_t             o_tab_r;

  logic                      slot_free;
  logic                      emit;
  logic                      last_beat;
  logic [gcg_pkg::NCAND-1:0] sel_oh;
  logic [gcg_pkg::NCAND-1:0] mask_rest;
  logic                      seen;
  gcg_pkg::tab_t             child;

  assign slot_free = !o_v_r || out_ch.ready;
  assign emit      = b_v_r && slot_free;

  // Lowest pending candidate goes out first.
  always_comb begin
    sel_oh = '0;
    seen   = 1'b0;
    for (int k = 0; k < gcg_pkg::NCAND; k++) begin
      if (b_mask_r[k] && !seen) begin
        sel_oh[k] = 1'b1;
        seen      = 1'b1;
      end
    end
  end

  assign mask_rest = b_mask_r & ~sel_oh;
  assign last_beat = (mask_rest == '0) || (b_cnt_r == gcg_pkg::CNT_W'(gcg_pkg::MAX_RESULTS - 1));
  assign a_take    = a_valid && (!b_v_r || (emit && last_beat));

  always_comb begin
    child = b_tab_r;
    if (sel_oh[0]) begin
      case (b_op_r)
        gcg_pkg::OP_GLCNAC: begin
          if (b_tab_r.cg < gcg_pkg::CORE_GLCNAC_FULL) begin
            child.cg = b_tab_r.cg + 2'd1;
          end else begin
            child.bs = 1'b1;
          end
        end
        gcg_pkg::OP_MAN: begin
          child.cm = b_tab_r.cm + 2'd1;
        end
        gcg_pkg::OP_FUC: begin
          child.cf = 1'b1;
        end
        default: begin
          child = b_tab_r;
        end
      endcase
    end
    // Growth on branches without a packed nibble is dropped.
    for (int k = 0; k < gcg_pkg::FLD_LANES; k++) begin
      if (sel_oh[k+1]) begin
        case (b_op_r)
          gcg_pkg::OP_GLCNAC: child.gn[k*4 +: 4] = b_tab_r.gn[k*4 +: 4] + 4'd1;
          gcg_pkg::OP_GAL:    child.ga[k*4 +: 4] = b_tab_r.ga[k*4 +: 4] + 4'd1;
          gcg_pkg::OP_FUC:    child.fu[k]        = 1'b1;
          gcg_pkg::OP_NEUAC:  child.na[k]        = 1'b1;
          gcg_pkg::OP_NEUGC:  child.ng[k]        = 1'b1;
          default:            child.fu[k]        = b_tab_r.fu[k];
        endcase
      end
    end
  end

  always_comb begin
    b_v_nxt    = b_v_r;
    b_mask_nxt = b_mask_r;
    b_cnt_nxt  = b_cnt_r;
    if (emit) begin
      b_mask_nxt = mask_rest;
      b_cnt_nxt  = b_cnt_r + gcg_pkg::CNT_W'(1);
      if (last_beat) begin
        b_v_nxt = 1'b0;
      end
    end
    if (a_take) begin
      b_v_nxt    = 1'b1;
      b_mask_nxt = a_mask;
      b_cnt_nxt  = '0;
    end
    o_v_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : o_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_mask_r <= b_mask_nxt;
    b_cnt_r  <= b_cnt_nxt;
    if (a_take) begin
      b_op_r  <= a_op;
      b_tab_r <= a_tab;
    end
    if (emit) begin
      o_has_r  <= (b_mask_r != '0);
      o_last_r <= last_beat;
      o_tab_r  <= (b_mask_r != '0) ? child : '0;
    end
  end

  assign out_ch.valid               = o_v_r;
  assign out_ch.has_child           = o_has_r;
  assign out_ch.last                = o_last_r;
  assign out_ch.child_core_glcnac   = o_tab_r.cg;
  assign out_ch.child_core_man      = o_tab_r.cm;
  assign out_ch.child_core_fuc      = o_tab_r.cf;
  assign out_ch.child_bisect        = o_tab_r.bs;
  assign out_ch.child_branch_glcnac = o_tab_r.gn;
  assign out_ch.child_branch_gal    = o_tab_r.ga;
  assign out_ch.child_branch_fuc    = o_tab_r.fu;
  assign out_ch.child_branch_neuac  = o_tab_r.na;
  assign out_ch.child_branch_neugc  = o_tab_r.ng;

endmodule

FILE: hw/rtl/gcg_checker.sv
// Port-level checks for the glycan child generator, bound to the top level.
module gcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_has_child,
  input logic        out_last,
  input logic [1:0]  out_cg,
  input logic [1:0]  out_cm,
  input logic        out_cf,
  input logic        out_bs,
  input logic [15:0] out_gn,
  input logic [15:0] out_ga,
  input logic [3:0]  out_fu,
  input logic [3:0]  out_na,
  input logic [3:0]  out_ng
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_beat;
  logic       out_done;

  assign in_beat  = in_valid && in_ready;
  assign out_done = out_valid && out_ready && out_last;
  assign pend_nxt = pend_r + {2'b0, in_beat} - {2'b0, out_done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_has_child) && $stable(out_last) &&
      $stable(out_gn) && $stable(out_ga))
    else $error("result beat changed while stalled");

  a_nochild: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_child |-> out_last && out_cg == 2'd0 && out_cm == 2'd0 &&
      !out_cf && !out_bs && out_gn == 16'd0 && out_ga == 16'd0 && out_fu == 4'd0 &&
      out_na == 4'd0 && out_ng == 4'd0)
    else $error("empty result is not a clean final beat");

  a_owned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result beat without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more items in flight than the block can hold");

endmodule

bind glycan_child_generator gcg_checker u_gcg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_has_child (out_ch.has_child),
  .out_last      (out_ch.last),
  .out_cg        (out_ch.child_core_glcnac),
  .out_cm        (out_ch.child_core_man),
  .out_cf        (out_ch.child_core_fuc),
  .out_bs        (out_ch.child_bisect),
  .out_gn        (out_ch.child_branch_glcnac),
  .out_ga        (out_ch.child_branch_gal),
  .out_fu        (out_ch.child_branch_fuc),
  .out_na        (out_ch.child_branch_neuac),
  .out_ng        (out_ch.child_branch_neugc)
);

FILE: tb/glycan_child_generator_tb.sv
// Self-checking testbench for the glycan child generator: directed and random structures against a predictor.
module glycan_child_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int HANG_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [2:0]     op;
    gcg_pkg::tab_t  tab;
  } glycan_req_t;

  typedef struct packed {
    logic           has_child;
    logic           last;
    gcg_pkg::tab_t  tab;
  } child_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gcg_in_if  in_ch ();
  gcg_out_if out_ch ();

  glycan_child_generator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  glycan_req_t structure_q[$];
  child_beat_t child_q[$];
  glycan_req_t offered;
  int structures_queued = 0;
  int structures_taken  = 0;
  int mismatches        = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_requests     = 0;
  int hold_served       = 0;
  int hold_left         = 0;
  int idle_cycles       = 0;

  function automatic int branch_count(logic [15:0] v, int i);
    return (i < gcg_pkg::FIELD_BRANCHES) ? int'(v[4*i +: 4]) : 0;
  endfunction

  function automatic int branch_bit(logic [3:0] v, int i);
    return (i < gcg_pkg::FIELD_BRANCHES) ? int'(v[i]) : 0;
  endfunction

  function automatic void keep_child(ref gcg_pkg::tab_t kids[$], input gcg_pkg::tab_t c);
    if (kids.size() < gcg_pkg::MAX_RESULTS) kids = {kids, c};
  endfunction

  function automatic void queue_structure(glycan_req_t r);
    structure_q = {structure_q, r};
  endfunction

  // Work out every child of one structure and queue the beats the block must send.
  function automatic void predict_children(glycan_req_t req);
    gcg_pkg::tab_t s;
    gcg_pkg::tab_t c;
    gcg_pkg::tab_t kids[$];
    child_beat_t   beat;
    int            g;
    int            a;
    logic [3:0]    sel;
    s = req.tab;
    case (req.op)
      gcg_pkg::OP_GLCNAC: begin
        if (s.cg < gcg_pkg::CORE_GLCNAC_FULL) begin
          c = s;
          c.cg = s.cg + 2'd1;
          keep_child(kids, c);
        end else if (s.cg == gcg_pkg::CORE_GLCNAC_FULL && s.cm == gcg_pkg::CORE_MAN_FULL) begin
          if (!s.bs && branch_count(s.gn, 0) == 0) begin
            c = s;
            c.bs = 1'b1;
            keep_child(kids, c);
          end
          for (int i = 0; i < gcg_pkg::BRANCHES; i++) begin
            g = branch_count(s.gn, i);
            if (i != 0 && !(g < branch_count(s.gn, i - 1))) continue;
            if (g == branch_count(s.ga, i) && branch_bit(s.fu, i) == 0 &&
                branch_bit(s.na, i) == 0 && branch_bit(s.ng, i) == 0 &&
                g < gcg_pkg::CNT_LIM) begin
              c = s;
              if (i < gcg_pkg::FIELD_BRANCHES) c.gn[4*i +: 4] = 4'(g + 1);
              keep_child(kids, c);
            end
          end
        end
      end
      gcg_pkg::OP_MAN: begin
        if (s.cg == gcg_pkg::CORE_GLCNAC_FULL && s.cm < gcg_pkg::CORE_MAN_FULL) begin
          c = s;
          c.cm = s.cm + 2'd1;
          keep_child(kids, c);
        end
      end
      gcg_pkg::OP_GAL: begin
        for (int i = 0; i < gcg_pkg::BRANCHES; i++) begin
          a = branch_count(s.ga, i);
          if (i != 0 && !(a < branch_count(s.ga, i - 1))) continue;
          if (branch_count(s.gn, i) == a + 1 && a < gcg_pkg::CNT_LIM) begin
            c = s;
            if (i < gcg_pkg::FIELD_BRANCHES) c.ga[4*i +: 4] = 4'(a + 1);
            keep_child(kids, c);
          end
        end
      end
      gcg_pkg::OP_FUC: begin
        if (s.cg == 2'd1 && s.cm == 2'd0 && !s.cf) begin
          c = s;
          c.cf = 1'b1;
          keep_child(kids, c);
        end else begin
          for (int i = 0; i < gcg_pkg::BRANCHES; i++) begin
            if (i != 0 && !(branch_bit(s.fu, i) < branch_bit(s.fu, i - 1))) continue;
            if (branch_bit(s.fu, i) == 0 && branch_count(s.gn, i) > 0) begin
              c = s;
              if (i < gcg_pkg::FIELD_BRANCHES) c.fu[i] = 1'b1;
              keep_child(kids, c);
            end
          end
        end
      end
      gcg_pkg::OP_NEUAC, gcg_pkg::OP_NEUGC: begin
        sel = (req.op == gcg_pkg::OP_NEUAC) ? s.na : s.ng;
        for (int i = 0; i < gcg_pkg::BRANCHES; i++) begin
          g = branch_count(s.gn, i);
          if (i != 0 && !(branch_bit(sel, i) < branch_bit(sel, i - 1))) continue;
          if (g > 0 && g == branch_count(s.ga, i) && branch_bit(s.na, i) == 0 &&
              branch_bit(s.ng, i) == 0) begin
            c = s;
            if (i < gcg_pkg::FIELD_BRANCHES) begin
              if (req.op == gcg_pkg::OP_NEUAC) c.na[i] = 1'b1;
              else c.ng[i] = 1'b1;
            end
            keep_child(kids, c);
          end
        end
      end
      default: ;
    endcase
    if (kids.size() == 0) begin
      beat = '0;
      beat.last = 1'b1;
      child_q = {child_q, beat};
    end else begin
      foreach (kids[k]) begin
        beat.has_child = 1'b1;
        beat.last      = (k == kids.size() - 1);
        beat.tab       = kids[k];
        child_q = {child_q, beat};
      end
    end
  endfunction

  function automatic glycan_req_t make_req(logic [2:0] op, logic [1:0] cg, logic [1:0] cm,
                                           logic cf, logic bs, logic [15:0] gn,
                                           logic [15:0] ga, logic [3:0] fu, logic [3:0] na,
                                           logic [3:0] ng);
    glycan_req_t r;
    r.op = op;
    r.tab = '{cg: cg, cm: cm, cf: cf, bs: bs, gn: gn, ga: ga, fu: fu, na: na, ng: ng};
    return r;
  endfunction

  // Mostly plausible structures: full core, descending branches, caps on finished arms.
  function automatic glycan_req_t rand_req();
    glycan_req_t r;
    int          nb;
    int          prev;
    int          g;
    int          a;
    r = '0;
    if ($urandom_range(99) < 20) begin
      r.op     = 3'($urandom);
      r.tab.cg = 2'($urandom);
      r.tab.cm = 2'($urandom);
      r.tab.cf = 1'($urandom);
      r.tab.bs = 1'($urandom);
      r.tab.gn = 16'($urandom);
      r.tab.ga = 16'($urandom);
      r.tab.fu = 4'($urandom);
      r.tab.na = 4'($urandom);
      r.tab.ng = 4'($urandom);
    end else begin
      r.op = 3'($urandom_range(5));
      if ($urandom_range(9) < 8) begin
        r.tab.cg = gcg_pkg::CORE_GLCNAC_FULL;
        r.tab.cm = ($urandom_range(3) > 0) ? gcg_pkg::CORE_MAN_FULL : 2'($urandom_range(2));
      end else begin
        r.tab.cg = 2'($urandom_range(1));
      end
      r.tab.cf = 1'($urandom_range(1));
      r.tab.bs = 1'($urandom_range(1));
      nb = $urandom_range(4);
      prev = ($urandom_range(9) == 0) ? $urandom_range(15, 12) : $urandom_range(4, 1);
      for (int i = 0; i < gcg_pkg::FIELD_BRANCHES; i++) begin
        g = (i >= nb) ? 0 : (i == 0) ? prev : $urandom_range(prev);
        a = (g > 0 && $urandom_range(2) == 0) ? g - 1 : g;
        r.tab.gn[4*i +: 4] = 4'(g);
        r.tab.ga[4*i +: 4] = 4'(a);
        r.tab.fu[i] = (g > 0 && $urandom_range(3) == 0);
        if (g > 0 && a == g) begin
          case ($urandom_range(3))
            0: r.tab.na[i] = 1'b1;
            1: r.tab.ng[i] = 1'b1;
            default: ;
          endcase
        end
        prev = g;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: present one structure at a time, hold it until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.op            <= '0;
      in_ch.core_glcnac   <= '0;
      in_ch.core_man      <= '0;
      in_ch.core_fuc      <= 1'b0;
      in_ch.bisect        <= 1'b0;
      in_ch.branch_glcnac <= '0;
      in_ch.branch_gal    <= '0;
      in_ch.branch_fuc    <= '0;
      in_ch.branch_neuac  <= '0;
      in_ch.branch_neugc  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_children(offered);
        structures_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (structure_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered = structure_q.pop_front();
          in_ch.op            <= offered.op;
          in_ch.core_glcnac   <= offered.tab.cg;
          in_ch.core_man      <= offered.tab.cm;
          in_ch.core_fuc      <= offered.tab.cf;
          in_ch.bisect        <= offered.tab.bs;
          in_ch.branch_glcnac <= offered.tab.gn;
          in_ch.branch_gal    <= offered.tab.ga;
          in_ch.branch_fuc    <= offered.tab.fu;
          in_ch.branch_neuac  <= offered.tab.na;
          in_ch.branch_neugc  <= offered.tab.ng;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each child beat against the oldest prediction, stall at random.
  always @(posedge clk) begin
    child_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (child_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual has_child=%0b last=%0b",
                   $time, out_ch.has_child, out_ch.last);
          mismatches++;
        end else begin
          want = child_q.pop_front();
          check_field("has_child", 16'(want.has_child), 16'(out_ch.has_child));
          check_field("last", 16'(want.last), 16'(out_ch.last));
          check_field("child_core_glcnac", 16'(want.tab.cg), 16'(out_ch.child_core_glcnac));
          check_field("child_core_man", 16'(want.tab.cm), 16'(out_ch.child_core_man));
          check_field("child_core_fuc", 16'(want.tab.cf), 16'(out_ch.child_core_fuc));
          check_field("child_bisect", 16'(want.tab.bs), 16'(out_ch.child_bisect));
          check_field("child_branch_glcnac", want.tab.gn, out_ch.child_branch_glcnac);
          check_field("child_branch_gal", want.tab.ga, out_ch.child_branch_gal);
          check_field("child_branch_fuc", 16'(want.tab.fu), 16'(out_ch.child_branch_fuc));
          check_field("child_branch_neuac", 16'(want.tab.na), 16'(out_ch.child_branch_neuac));
          check_field("child_branch_neugc", 16'(want.tab.ng), 16'(out_ch.child_branch_neugc));
        end
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog: give up when work is pending but no beat moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (in_ch.valid || child_q.size() > 0) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    sender_idle_pct   = 38;
    receiver_idle_pct = 61;
    // Core growth on empty and half-built cores.
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, 2'd0, 2'd0, 0, 0, 16'h0000, 16'h0000,
                             0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, 2'd1, 2'd0, 0, 0, 16'h0000, 16'h0000,
                             0, 0, 0));
    // Full core: bisect plus first antenna, then four staggered antennae.
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h0000, 16'h0000, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 1, 1, 16'h0123, 16'h0123, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h0111, 16'h0111, 4'h1, 0, 0));
    // Saturated first branch: growth suppressed, next branch still grows.
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 1, 16'h000F, 16'h000F, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, gcg_pkg::CORE_GLCNAC_FULL, 2'd2, 0, 0,
                             16'h0000, 16'h0000, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_MAN, gcg_pkg::CORE_GLCNAC_FULL, 2'd0, 0, 0,
                             0, 0, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_MAN, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 0, 0, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_MAN, 2'd1, 2'd0, 0, 0, 0, 0, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GAL, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h1222, 16'h0011, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_GAL, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'hFEDC, 16'hEDCB, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_FUC, 2'd1, 2'd0, 0, 0, 0, 0, 0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_FUC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 1, 0, 16'h1111, 16'h1111, 4'h0, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_FUC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 1, 0, 16'h1111, 16'h1111, 4'h1, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_FUC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 1, 0, 16'h1111, 16'h1111, 4'hF, 0, 0));
    queue_structure(make_req(gcg_pkg::OP_NEUAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h1111, 16'h1111, 0, 4'h0, 0));
    queue_structure(make_req(gcg_pkg::OP_NEUAC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h1111, 16'h1111, 0, 4'h3, 0));
    queue_structure(make_req(gcg_pkg::OP_NEUGC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h1111, 16'h1111, 0, 4'h1,
                             4'h0));
    queue_structure(make_req(gcg_pkg::OP_NEUGC, gcg_pkg::CORE_GLCNAC_FULL,
                             gcg_pkg::CORE_MAN_FULL, 0, 0, 16'h2211, 16'h2211, 0, 0, 4'h1));
    // Unused sugar codes, all-ones and all-zero tables.
    queue_structure(make_req(OP_SPARE_6, gcg_pkg::CORE_GLCNAC_FULL, gcg_pkg::CORE_MAN_FULL,
                             0, 0, 16'h0111, 16'h0111, 0, 0, 0));
    queue_structure(make_req(OP_SPARE_7, 2'd3, 2'd3, 1, 1,
                             16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF));
    queue_structure(make_req(gcg_pkg::OP_GLCNAC, 2'd3, 2'd3, 1, 1,
                             16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF));
    queue_structure(make_req(gcg_pkg::OP_FUC, 2'd0, 2'd0, 0, 0, 0, 0, 0, 0, 0));
    repeat (100) queue_structure(rand_req());
    structures_queued = structure_q.size();
    while (structures_taken != structures_queued || child_q.size() > 0) @(negedge clk);

    sender_idle_pct   = 61;
    receiver_idle_pct = 38;
    repeat (100) queue_structure(rand_req());
    structures_queued += 100;
    while (structures_taken != structures_queued || child_q.size() > 0) @(negedge clk);

    // Back-to-back with a long receiver hold so the input side backs up.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_requests++;
    repeat (86) queue_structure(rand_req());
    structures_queued += 86;
    while (structures_taken != structures_queued || child_q.size() > 0) @(negedge clk);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (child_q.size() > 0)
      $display("%0t: %0d expected beats never arrived", $time, child_q.size());
    if (mismatches == 0 && child_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
